// ----- src/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

   localparam int LENGTH_BITS_DEF = 64;
   localparam int RSP_LEN_W       = 64;
   localparam int QDEPTH          = 4;
   localparam int QIDX_W          = $clog2(QDEPTH);
   localparam int QCNT_W          = $clog2(QDEPTH + 1);

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_TRUNC   = 2'd2;

   localparam logic [6:0] LEN_CODE16 = 7'd126;
   localparam logic [6:0] LEN_CODE64 = 7'd127;
   localparam logic [2:0] EXT16_BYTES = 3'd2;
   // eight bytes, held modulo 8
   localparam logic [2:0] EXT64_BYTES = 3'd0;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_PAYLOAD,
      PH_DISCARD
   } wsdf_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_last;
   } wsdf_req_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           payload_byte;
      logic                 fin_bit;
      logic [2:0]           rsv_bits;
      logic [3:0]           opcode;
      logic                 mask_bit;
      logic [RSP_LEN_W-1:0] payload_length;
      logic [RSP_LEN_W-1:0] frame_bytes;
   } wsdf_rsp_type;

endpackage

// ----- src/websocket_frame_deframer.sv -----
// WebSocket frame deframer: header parse, payload unmask, result queue.
// Results pass through the registered result queue before they appear on rsp.
// Throughput: one byte per cycle while req_stall is low; a byte yields at most two result beats.
// req_stall rises while three or more result beats wait in the 4-entry queue.
// Reset (synchronous, active high) restarts parsing at a frame start and empties the queue.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wsdf_pkg::wsdf_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wsdf_pkg::wsdf_rsp_type rsp_data
);

   localparam int QD = wsdf_pkg::QDEPTH;
   localparam int CW = wsdf_pkg::QCNT_W;
   localparam int LW = wsdf_pkg::RSP_LEN_W;

   wsdf_pkg::wsdf_phase_type phase_ff, phase_in;
   logic [7:0]             fhb_ff, fhb_in;
   logic                   masked_ff, masked_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [2:0]             ext_ff, ext_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             kidx_ff, kidx_in;
   logic [3:0]             hbc_ff, hbc_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   wsdf_pkg::wsdf_rsp_type q_ff [QD];
   wsdf_pkg::wsdf_rsp_type q_in [QD];
   logic [CW-1:0]          cnt_ff, cnt_in;

   logic       accept, pop;
   logic [7:0] b;
   logic [7:0] kbyte;
   logic [7:0] pay_byte;
   logic       pay_ev, done_ev, trunc_ev, len_done, hdr_done;
   logic [LW:0]   total;
   logic [LW-1:0] frame_total;
   wsdf_pkg::wsdf_rsp_type r_pay, r_done, r_trunc, push_a, push_b;
   logic [1:0]    n_push;
   logic [CW-1:0] base;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = cnt_ff >= CW'(QD - 1);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_ff[0];
   assign b         = req_data.in_byte;

   always_comb begin
      unique case (kidx_ff)
         2'd0: kbyte = key_ff[31:24];
         2'd1: kbyte = key_ff[23:16];
         2'd2: kbyte = key_ff[15:8];
         2'd3: kbyte = key_ff[7:0];
      endcase
   end

   // parser next state
   always_comb begin
      phase_in  = phase_ff;
      fhb_in    = fhb_ff;
      masked_in = masked_ff;
      len_in    = len_ff;
      ext_in    = ext_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      hbc_in    = hbc_ff;
      rem_in    = rem_ff;
      pay_ev    = 1'b0;
      done_ev   = 1'b0;
      trunc_ev  = 1'b0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      pay_byte  = 8'h00;
      if (accept) begin
         unique case (phase_ff)
            wsdf_pkg::PH_HDR0: begin
               fhb_in    = b;
               masked_in = 1'b0;
               len_in    = '0;
               ext_in    = 3'd0;
               key_in    = 32'h0;
               kidx_in   = 2'd0;
               rem_in    = '0;
               hbc_in    = 4'd1;
               phase_in  = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1: begin
               masked_in = b[7];
               hbc_in    = 4'd2;
               if (b[6:0] == wsdf_pkg::LEN_CODE16) begin
                  ext_in   = wsdf_pkg::EXT16_BYTES;
                  phase_in = wsdf_pkg::PH_EXT;
               end else if (b[6:0] == wsdf_pkg::LEN_CODE64) begin
                  ext_in   = wsdf_pkg::EXT64_BYTES;
                  phase_in = wsdf_pkg::PH_EXT;
               end else begin
                  len_in   = LENGTH_BITS'(b[6:0]);
                  len_done = 1'b1;
               end
            end
            wsdf_pkg::PH_EXT: begin
               hbc_in = hbc_ff + 4'd1;
               if (len_ff[LENGTH_BITS-1 -: 8] != 8'h00) begin
                  len_in = '1;
               end else begin
                  len_in = {len_ff[LENGTH_BITS-9:0], b};
               end
               ext_in = ext_ff - 3'd1;
               if (ext_ff == 3'd1) begin
                  len_done = 1'b1;
               end
            end
            wsdf_pkg::PH_KEY: begin
               hbc_in  = hbc_ff + 4'd1;
               key_in  = {key_ff[23:0], b};
               kidx_in = kidx_ff + 2'd1;
               if (kidx_ff == 2'd3) begin
                  hdr_done = 1'b1;
               end
            end
            wsdf_pkg::PH_PAYLOAD: begin
               pay_ev   = 1'b1;
               pay_byte = masked_ff ? (b ^ kbyte) : b;
               kidx_in  = kidx_ff + 2'd1;
               rem_in   = rem_ff - LENGTH_BITS'(1);
               if (rem_ff == LENGTH_BITS'(1)) begin
                  done_ev = 1'b1;
               end
            end
            wsdf_pkg::PH_DISCARD: begin
               phase_in = wsdf_pkg::PH_DISCARD;
            end
            default: begin
               phase_in = wsdf_pkg::PH_DISCARD;
            end
         endcase
         if (len_done) begin
            if (masked_in) begin
               kidx_in  = 2'd0;
               phase_in = wsdf_pkg::PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end
         if (hdr_done) begin
            rem_in  = len_in;
            kidx_in = 2'd0;
            if (len_in == '0) begin
               done_ev = 1'b1;
            end else begin
               phase_in = wsdf_pkg::PH_PAYLOAD;
            end
         end
         if (done_ev) begin
            phase_in = wsdf_pkg::PH_DISCARD;
         end
         if (req_data.buffer_last) begin
            trunc_ev = phase_in != wsdf_pkg::PH_DISCARD;
            phase_in = wsdf_pkg::PH_HDR0;
         end
      end
   end

   // result beats
   always_comb begin
      total       = {1'b0, LW'(len_in)} + (LW + 1)'(hbc_in);
      frame_total = total[LW] ? '1 : total[LW-1:0];

      r_pay.kind           = wsdf_pkg::KIND_PAYLOAD;
      r_pay.payload_byte   = pay_byte;
      r_pay.fin_bit        = fhb_in[7];
      r_pay.rsv_bits       = fhb_in[6:4];
      r_pay.opcode         = fhb_in[3:0];
      r_pay.mask_bit       = masked_in;
      r_pay.payload_length = LW'(len_in);
      r_pay.frame_bytes    = '0;

      r_done              = r_pay;
      r_done.kind         = wsdf_pkg::KIND_DONE;
      r_done.payload_byte = 8'h00;
      r_done.frame_bytes  = frame_total;

      r_trunc              = r_pay;
      r_trunc.kind         = wsdf_pkg::KIND_TRUNC;
      r_trunc.payload_byte = 8'h00;

      push_b = done_ev ? r_done : r_trunc;
      push_a = pay_ev ? r_pay : push_b;
      n_push = {1'b0, pay_ev} + {1'b0, done_ev} + {1'b0, trunc_ev};
   end

   // result queue, head at entry 0
   always_comb begin
      base = cnt_ff - CW'(pop);
      for (int i = 0; i < QD; i++) begin
         if (pop && (i < QD - 1)) begin
            q_in[i] = q_ff[(i + 1) % QD];
         end else begin
            q_in[i] = q_ff[i];
         end
         if ((n_push != 2'd0) && (base == CW'(i))) begin
            q_in[i] = push_a;
         end
         if ((n_push == 2'd2) && (base + CW'(1) == CW'(i))) begin
            q_in[i] = push_b;
         end
      end
      cnt_in = cnt_ff - CW'(pop) + CW'(n_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsdf_pkg::PH_HDR0;
         fhb_ff    <= 8'h00;
         masked_ff <= 1'b0;
         len_ff    <= '0;
         ext_ff    <= 3'd0;
         key_ff    <= 32'h0;
         kidx_ff   <= 2'd0;
         hbc_ff    <= 4'd0;
         rem_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         fhb_ff    <= fhb_in;
         masked_ff <= masked_in;
         len_ff    <= len_in;
         ext_ff    <= ext_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
         hbc_ff    <= hbc_in;
         rem_ff    <= rem_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

// ----- src/wsdf_checker.sv -----
// Port-level checks for the WebSocket frame deframer, bound to the top level.
module wsdf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input wsdf_pkg::wsdf_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input wsdf_pkg::wsdf_rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input beat changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != wsdf_pkg::KIND_PAYLOAD) |-> rsp_data.payload_byte == 8'h00)
      else $error("payload_byte set on non-payload beat");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != wsdf_pkg::KIND_DONE) |-> rsp_data.frame_bytes == '0)
      else $error("frame_bytes set on non-complete beat");

   a_total_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == wsdf_pkg::KIND_DONE)
         |-> rsp_data.frame_bytes >= rsp_data.payload_length)
      else $error("frame total below payload length");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);
